// ===== src/mlp_pkg.sv =====
// Shared constants, lamp record layout and controller/datapath interface types
// for the multiplexed lamp persistence block. No dependencies.
`timescale 1ns / 1ps

package mlp_pkg;

  localparam int LAMP_COUNT   = 256;
  localparam int COLUMN_WIDTH = 16;
  localparam int NUM_COLUMNS  = LAMP_COUNT / COLUMN_WIDTH;
  localparam int LAMP_AW      = $clog2(LAMP_COUNT);
  localparam int COL_AW       = $clog2(NUM_COLUMNS);
  localparam int BIT_AW       = $clog2(COLUMN_WIDTH);
  localparam int LVL_W        = 6;
  localparam int STEP_W       = 19;

  localparam logic [22:0] SAT_LIMIT = 23'd5000000;
  // floor(2^24 / 63), used for the divide-by-63 of the timing registers
  localparam logic [18:0] RECIP_63  = 19'd266305;

  localparam logic [23:0] GLOW_RESET = 24'd4651;
  localparam logic [23:0] FADE_RESET = 24'd534883;

  // input item function codes
  localparam logic [1:0] FUNC_COL   = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_MUX   = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_GLOW      = 2'd0;
  localparam logic [1:0] REG_FADE      = 2'd1;
  localparam logic [1:0] REG_INTENSITY = 2'd2;
  localparam logic [1:0] REG_MUX_DRIVE = 2'd3;

  typedef struct packed {
    logic signed [24:0] on_time;
    logic [22:0]        off_time;
    logic [23:0]        peak_on_time;
    logic signed [24:0] prev_on_time;
    logic [LVL_W-1:0]   held_level;
  } lamp_rec_t;

  localparam int REC_W = $bits(lamp_rec_t);

  typedef struct packed {
    logic               rd_en;
    logic               rd_qry;
    logic [LAMP_AW-1:0] rd_addr;
    logic               chg_wr;
    logic               div_ld;
    logic               corr_ld;
    logic               srch_en;
    logic [2:0]         srch_bit;
    logic               q_fin;
  } mlp_cmd_t;

  typedef struct packed {
    logic charge;
    logic query;
  } mlp_sts_t;

endpackage

// ===== src/mlp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/mlp_ctrl.sv =====
// Controller state machine: sequences the charge sweep over all lamps and the
// query steps. Depends on mlp_pkg.
`timescale 1ns / 1ps

module mlp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mlp_pkg::mlp_sts_t sts,
  output logic              busy,
  output mlp_pkg::mlp_cmd_t cmd
);
  import mlp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_QRD   = 3'd2;
  localparam logic [2:0] S_QDIV  = 3'd3;
  localparam logic [2:0] S_QCORR = 3'd4;
  localparam logic [2:0] S_QSRCH = 3'd5;
  localparam logic [2:0] S_QOUT  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [LAMP_AW:0] cnt_r, cnt_nxt;

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          if (sts.charge) begin
            state_nxt = S_SWEEP;
          end else if (sts.query) begin
            state_nxt = S_QRD;
          end
        end
      end
      S_SWEEP: begin
        cmd.rd_en   = ~cnt_r[LAMP_AW];
        cmd.rd_addr = cnt_r[LAMP_AW-1:0];
        cmd.chg_wr  = (cnt_r != '0);
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r[LAMP_AW]) begin
          state_nxt = S_IDLE;
        end
      end
      S_QRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_qry = 1'b1;
        state_nxt  = S_QDIV;
      end
      S_QDIV: begin
        cmd.div_ld = 1'b1;
        state_nxt  = S_QCORR;
      end
      S_QCORR: begin
        cmd.corr_ld = 1'b1;
        cnt_nxt     = (LAMP_AW+1)'(LVL_W - 1);
        state_nxt   = S_QSRCH;
      end
      S_QSRCH: begin
        cmd.srch_en  = 1'b1;
        cmd.srch_bit = cnt_r[2:0];
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_QOUT;
        end
      end
      S_QOUT: begin
        cmd.q_fin = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== src/mlp_dpath.sv =====
// Datapath: column and mux state, elapsed time, lamp record memory, charge
// arithmetic, level search and brightness. Depends on mlp_pkg and mlp_ram.
`timescale 1ns / 1ps

module mlp_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        in_func,
  input  logic [15:0]       in_column_data,
  input  logic [15:0]       in_cycles,
  input  logic [3:0]        in_mux_select,
  input  logic [7:0]        in_lamp_index,
  input  logic [23:0]       glow_time,
  input  logic [23:0]       fade_time,
  input  logic [7:0]        intensity,
  input  logic              mux_drive,
  input  mlp_pkg::mlp_cmd_t cmd,
  output mlp_pkg::mlp_sts_t sts,
  output logic              out_valid,
  output logic              out_lamp_on,
  output logic [7:0]        out_brightness,
  output logic [5:0]        out_level
);
  import mlp_pkg::*;

  logic [COLUMN_WIDTH-1:0] col_bits_r  [NUM_COLUMNS];
  logic [COLUMN_WIDTH-1:0] prev_bits_r [NUM_COLUMNS];
  logic [COL_AW-1:0]       active_r, seen_r;
  logic [22:0]             elapsed_r, e_r;
  logic [COLUMN_WIDTH-1:0] pwr_bits_r;
  logic [LAMP_AW-1:0]      lamp_r, lag_r;
  logic [LAMP_COUNT-1:0]   valid_r;
  logic                    vld_q_r;

  logic [23:0]             tick_sum;
  logic [22:0]             tick_sat;
  logic                    mux_moved;

  logic [LAMP_AW-1:0]      rd_addr;
  logic [REC_W-1:0]        ram_q;
  lamp_rec_t               cur;
  lamp_rec_t               chg, qwb;
  logic                    wr_en;
  logic [REC_W-1:0]        wr_data;

  assign tick_sum  = {1'b0, elapsed_r} + {8'd0, in_cycles};
  assign tick_sat  = (tick_sum > {1'b0, SAT_LIMIT}) ? SAT_LIMIT : tick_sum[22:0];
  assign mux_moved = (seen_r != active_r);

  assign sts.charge = (in_func == FUNC_COL) || ((in_func == FUNC_TICK) && mux_moved && mux_drive);
  assign sts.query  = (in_func == FUNC_QUERY);

  // column, mux and elapsed-time state, updated when an item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        col_bits_r[i]  <= '0;
        prev_bits_r[i] <= '0;
      end
      active_r  <= '0;
      seen_r    <= '0;
      elapsed_r <= '0;
    end else if (accept) begin
      case (in_func)
        FUNC_COL: begin
          prev_bits_r[active_r] <= col_bits_r[active_r];
          col_bits_r[active_r]  <= in_column_data;
          elapsed_r             <= '0;
        end
        FUNC_TICK: begin
          if (mux_moved) begin
            seen_r <= active_r;
          end
          elapsed_r <= (mux_moved && mux_drive) ? 23'd0 : tick_sat;
        end
        FUNC_MUX: begin
          active_r <= in_mux_select;
        end
        default: begin
        end
      endcase
    end
  end

  // sweep operands and query lamp, captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      lamp_r <= in_lamp_index;
      if (in_func == FUNC_COL) begin
        e_r        <= elapsed_r;
        pwr_bits_r <= col_bits_r[active_r];
      end else begin
        e_r        <= tick_sat;
        pwr_bits_r <= prev_bits_r[active_r];
      end
    end
  end

  // lamp record memory; an entry never written reads as zero
  assign rd_addr = cmd.rd_qry ? lamp_r : cmd.rd_addr;

  mlp_ram #(.WIDTH(REC_W), .DEPTH(LAMP_COUNT)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lag_r),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      lag_r   <= rd_addr;
      vld_q_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[lag_r] <= 1'b1;
    end
  end

  assign cur = vld_q_r ? lamp_rec_t'(ram_q) : lamp_rec_t'('0);

  // charge one lamp with the elapsed time
  logic                    powered;
  logic signed [25:0]      on_pos, on_sum, on_dec;
  logic signed [24:0]      on_new;
  logic [23:0]             off_sum;
  localparam logic signed [25:0] SAT_POS = $signed({3'b000, SAT_LIMIT});
  localparam logic signed [25:0] SAT_NEG = -SAT_POS;

  assign powered = (lag_r[LAMP_AW-1:BIT_AW] == active_r) && pwr_bits_r[lag_r[BIT_AW-1:0]];

  always_comb begin
    on_pos  = cur.on_time[24] ? 26'sd0 : 26'(cur.on_time);
    on_sum  = on_pos + $signed({3'b000, e_r});
    on_dec  = 26'(cur.on_time) - $signed({3'b000, e_r});
    off_sum = {1'b0, cur.off_time} + {1'b0, e_r};
    chg     = cur;
    if (powered) begin
      on_new           = (on_sum > SAT_POS) ? 25'(SAT_POS) : on_sum[24:0];
      chg.on_time      = on_new;
      if (cur.prev_on_time < on_new) begin
        chg.peak_on_time = on_new[23:0];
      end
      chg.prev_on_time = on_new;
      chg.off_time     = '0;
    end else begin
      on_new       = (on_dec < SAT_NEG) ? 25'(SAT_NEG) : on_dec[24:0];
      chg.on_time  = on_new;
      chg.off_time = (off_sum > {1'b0, SAT_LIMIT}) ? SAT_LIMIT : off_sum[22:0];
    end
  end

  // query: step sizes by reciprocal multiply, then bitwise level search
  lamp_rec_t          rec_r;
  logic [42:0]        prod_g_r, prod_f_r;
  logic [STEP_W-1:0]  step_on_r, step_off_r;
  logic [23:0]        x1_r, x2_r;
  logic [LVL_W-1:0]   c1_r, c2_r;
  logic               off_zero;

  function automatic logic [STEP_W-1:0] fix_step(input logic [42:0] prod,
                                                 input logic [23:0] num);
    logic [STEP_W-1:0] q0;
    logic [24:0]       rem;
    begin
      q0  = prod[24+STEP_W-1:24];
      rem = {1'b0, num} - ({6'd0, q0} << 6) + {6'd0, q0};
      fix_step = (rem >= 25'd63) ? q0 + 1'b1 : q0;
    end
  endfunction

  function automatic logic [LVL_W-1:0] srch(input logic [23:0] x,
                                            input logic [STEP_W-1:0] s,
                                            input logic [LVL_W-1:0] c,
                                            input logic [2:0] b);
    logic [LVL_W-1:0]        trial;
    logic [STEP_W+LVL_W-1:0] p;
    begin
      trial = c | (LVL_W'(1) << b);
      p     = STEP_W'(s) * trial;
      srch  = ({(STEP_W+LVL_W-24)'(0), x} > p) ? trial : c;
    end
  endfunction

  assign off_zero = (rec_r.off_time == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_ld) begin
      rec_r    <= cur;
      prod_g_r <= 43'(glow_time) * 43'(RECIP_63);
      prod_f_r <= 43'(fade_time) * 43'(RECIP_63);
    end
    if (cmd.corr_ld) begin
      step_on_r  <= fix_step(prod_g_r, glow_time);
      step_off_r <= fix_step(prod_f_r, fade_time);
      x1_r       <= off_zero ? (rec_r.on_time[24] ? 24'd0 : rec_r.on_time[23:0])
                             : rec_r.peak_on_time;
      x2_r       <= {1'b0, rec_r.off_time};
      c1_r       <= '0;
      c2_r       <= '0;
    end
    if (cmd.srch_en) begin
      c1_r <= srch(x1_r, step_on_r, c1_r, cmd.srch_bit);
      c2_r <= srch(x2_r, step_off_r, c2_r, cmd.srch_bit);
    end
  end

  // level, brightness and held-level writeback
  logic [LVL_W-1:0] lvl;
  logic [7:0]       bvar;
  logic [15:0]      bprod;
  logic [16:0]      bdiv;

  always_comb begin
    if (off_zero) begin
      lvl = (rec_r.held_level > c1_r) ? rec_r.held_level : c1_r;
    end else begin
      lvl = (c1_r > c2_r) ? c1_r - c2_r : '0;
    end
    bvar  = {1'b0, lvl, 1'b0} + 8'd129;
    bprod = intensity * bvar;
    // exact floor(x / 255) for a 16-bit x up to 65534
    bdiv  = ({1'b0, bprod} + 17'd1 + {9'd0, bprod[15:8]}) >> 8;
    qwb            = rec_r;
    qwb.held_level = lvl;
  end

  assign wr_en   = cmd.chg_wr || (cmd.q_fin && !off_zero);
  assign wr_data = cmd.chg_wr ? REC_W'(chg) : REC_W'(qwb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.q_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_fin) begin
      out_level      <= lvl;
      out_lamp_on    <= (lvl != '0);
      out_brightness <= (lvl != '0) ? bdiv[7:0] : 8'd0;
    end
  end

endmodule

// ===== src/multiplexed_lamp_persistence_top.sv =====
// Top level of the multiplexed lamp persistence block: APB register file,
// controller and datapath. Depends on mlp_pkg, mlp_ctrl and mlp_dpath.
//
//  channel   handshake                      payload
//  input     start / busy                   in_func, in_column_data, in_cycles,
//                                           in_mux_select, in_lamp_index
//  result    out_valid (one-cycle strobe)   out_lamp_on, out_brightness, out_level
//  config    psel/penable/pwrite/pready     paddr, pwdata, prdata
//
// Column write and charging tick: busy from the accepting edge through the sweep
// that reads and rewrites one lamp record per cycle.
// Query: busy through record read, step division, correction, the six-step level
// search and output; result strobe in the cycle that busy drops. Other items leave busy low.
// Reset (rst_n low, synchronous) clears all state at once via valid bits.
// The receiver cannot stall results.
`timescale 1ns / 1ps

module multiplexed_lamp_persistence_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_column_data,
  input  logic [15:0] in_cycles,
  input  logic [3:0]  in_mux_select,
  input  logic [7:0]  in_lamp_index,
  output logic        out_valid,
  output logic        out_lamp_on,
  output logic [7:0]  out_brightness,
  output logic [5:0]  out_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mlp_pkg::*;

  logic [23:0] glow_r, fade_r;
  logic [7:0]  intensity_r;
  logic        mux_drive_r;
  logic        accept;
  mlp_cmd_t    cmd;
  mlp_sts_t    sts;

  assign pready = 1'b1;
  assign accept = start && !busy;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glow_r      <= GLOW_RESET;
      fade_r      <= FADE_RESET;
      intensity_r <= '0;
      mux_drive_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_GLOW:      glow_r      <= pwdata[23:0];
        REG_FADE:      fade_r      <= pwdata[23:0];
        REG_INTENSITY: intensity_r <= pwdata[7:0];
        REG_MUX_DRIVE: mux_drive_r <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_GLOW:      prdata = {8'd0, glow_r};
      REG_FADE:      prdata = {8'd0, fade_r};
      REG_INTENSITY: prdata = {24'd0, intensity_r};
      REG_MUX_DRIVE: prdata = {31'd0, mux_drive_r};
      default:       prdata = '0;
    endcase
  end

  mlp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  mlp_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_func        (in_func),
    .in_column_data (in_column_data),
    .in_cycles      (in_cycles),
    .in_mux_select  (in_mux_select),
    .in_lamp_index  (in_lamp_index),
    .glow_time      (glow_r),
    .fade_time      (fade_r),
    .intensity      (intensity_r),
    .mux_drive      (mux_drive_r),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_lamp_on    (out_lamp_on),
    .out_brightness (out_brightness),
    .out_level      (out_level)
  );

endmodule

// ===== tb/mlp_checker.sv =====
// Scoreboard for the multiplexed lamp persistence block: tracks register writes,
// predicts query results from accepted items and compares them. Depends on mlp_pkg.
`timescale 1ns / 1ps

module mlp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_column_data,
  input  logic [15:0] in_cycles,
  input  logic [3:0]  in_mux_select,
  input  logic [7:0]  in_lamp_index,
  input  logic        out_valid,
  input  logic        out_lamp_on,
  input  logic [7:0]  out_brightness,
  input  logic [5:0]  out_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  import mlp_pkg::*;

  typedef struct {
    logic       lit;
    logic [7:0] bright;
    logic [5:0] lvl;
  } lamp_reading_t;

  localparam int SAT = 5000000;

  // configuration copy
  logic [23:0] glow_q;
  logic [23:0] fade_q;
  logic [7:0]  intensity_q;
  logic        mux_drive_q;

  // lamp and column state copy
  logic signed [24:0] lamp_on_t[LAMP_COUNT];
  logic [22:0]        lamp_off_t[LAMP_COUNT];
  logic [23:0]        lamp_peak[LAMP_COUNT];
  logic signed [24:0] lamp_prev_on[LAMP_COUNT];
  logic [5:0]         lamp_held[LAMP_COUNT];
  logic [15:0]        col_now[NUM_COLUMNS];
  logic [15:0]        col_prev[NUM_COLUMNS];
  logic [3:0]         active_col;
  logic [3:0]         seen_col;
  int                 elapsed;

  lamp_reading_t expected_readings[$];

  assign pending = expected_readings.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // charge elapsed time to every lamp using the active column's previous bits
  task automatic charge_all();
    int v;
    int f;
    logic powered;
    for (int i = 0; i < LAMP_COUNT; i++) begin
      powered = (i / COLUMN_WIDTH == active_col) && col_prev[active_col][i % COLUMN_WIDTH];
      if (powered) begin
        v = (lamp_on_t[i] < 0) ? 0 : int'(lamp_on_t[i]);
        v = v + elapsed;
        if (v > SAT) v = SAT;
        lamp_on_t[i] = v;
        if (int'(lamp_prev_on[i]) < v) lamp_peak[i] = v;
        lamp_prev_on[i] = v;
        lamp_off_t[i] = '0;
      end else begin
        f = int'(lamp_off_t[i]) + elapsed;
        v = int'(lamp_on_t[i]) - elapsed;
        lamp_off_t[i] = (f > SAT) ? SAT : f;
        lamp_on_t[i] = (v < -SAT) ? -SAT : v;
      end
    end
    elapsed = 0;
  endtask

  function automatic int glow_steps(input int x, input int step);
    int c;
    if (x == 0) return 0;
    if (step == 0) return 63;
    c = (x - 1) / step;
    return (c > 63) ? 63 : c;
  endfunction

  // evaluate one lamp, updating its held level when it is fading
  function automatic lamp_reading_t read_lamp(input int n);
    lamp_reading_t r;
    int lvl;
    int up;
    int down;
    int b;
    if (lamp_off_t[n] == 0) begin
      lvl = glow_steps((lamp_on_t[n] < 0) ? 0 : int'(lamp_on_t[n]), int'(glow_q) / 63);
      if (int'(lamp_held[n]) > lvl) lvl = lamp_held[n];
    end else begin
      up = glow_steps(int'(lamp_peak[n]), int'(glow_q) / 63);
      down = glow_steps(int'(lamp_off_t[n]), int'(fade_q) / 63);
      lvl = (up > down) ? up - down : 0;
      lamp_held[n] = lvl;
    end
    r.lit = (lvl > 0);
    r.lvl = lvl;
    b = (lvl * 2 + 129) & 8'hff;
    r.bright = (lvl > 0) ? (int'(intensity_q) * b) / 255 : 0;
    return r;
  endfunction

  always @(posedge clk) begin
    int t;
    lamp_reading_t want;
    if (!rst_n) begin
      glow_q      <= GLOW_RESET;
      fade_q      <= FADE_RESET;
      intensity_q <= '0;
      mux_drive_q <= 1'b0;
      for (int i = 0; i < LAMP_COUNT; i++) begin
        lamp_on_t[i] = '0; lamp_off_t[i] = '0; lamp_peak[i] = '0;
        lamp_prev_on[i] = '0; lamp_held[i] = '0;
      end
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        col_now[c] = '0; col_prev[c] = '0;
      end
      active_col = '0;
      seen_col   = '0;
      elapsed    = 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_GLOW:      glow_q      <= pwdata[23:0];
          REG_FADE:      fade_q      <= pwdata[23:0];
          REG_INTENSITY: intensity_q <= pwdata[7:0];
          REG_MUX_DRIVE: mux_drive_q <= pwdata[0];
          default: ;
        endcase
      end
      // predict on each accepted item
      if (start && !busy) begin
        case (in_func)
          FUNC_COL: begin
            col_prev[active_col] = col_now[active_col];
            col_now[active_col]  = in_column_data;
            charge_all();
          end
          FUNC_TICK: begin
            t = elapsed + in_cycles;
            elapsed = (t > SAT) ? SAT : t;
            if (seen_col != active_col) begin
              seen_col = active_col;
              if (mux_drive_q) charge_all();
            end
          end
          FUNC_MUX: active_col = in_mux_select;
          default: expected_readings.push_back(read_lamp(in_lamp_index));
        endcase
      end
      // compare each result with the oldest prediction
      if (out_valid) begin
        if (expected_readings.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = expected_readings.pop_front();
          if (out_lamp_on !== want.lit) report("lamp_on", out_lamp_on, want.lit);
          if (out_brightness !== want.bright) report("brightness", out_brightness, want.bright);
          if (out_level !== want.lvl) report("level", out_level, want.lvl);
        end
      end
    end
  end

  initial errors = 0;

endmodule

// ===== tb/multiplexed_lamp_persistence_top_test.sv =====
// Stimulus and verdict for the multiplexed lamp persistence block: directed and
// random items over several register settings. Depends on mlp_pkg, mlp_checker.
`timescale 1ns / 1ps

module multiplexed_lamp_persistence_top_test;
  import mlp_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = FUNC_TICK;
  logic [15:0] in_column_data = '0;
  logic [15:0] in_cycles = '0;
  logic [3:0]  in_mux_select = '0;
  logic [7:0]  in_lamp_index = '0;
  logic        out_valid;
  logic        out_lamp_on;
  logic [7:0]  out_brightness;
  logic [5:0]  out_level;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          cycle_count = 0;
  int          burst_left = 0;
  logic [3:0]  cur_col = '0;

  multiplexed_lamp_persistence_top dut (.*);

  mlp_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // hold the item until the block takes it, then maybe open a gap
  task automatic send_item(input logic [1:0] f, input logic [15:0] data,
                           input logic [15:0] cyc, input logic [3:0] col,
                           input logic [7:0] idx);
    int gap;
    @(negedge clk);
    start <= 1'b1; in_func <= f; in_column_data <= data;
    in_cycles <= cyc; in_mux_select <= col; in_lamp_index <= idx;
    if (f == FUNC_MUX) cur_col = col;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // drop start, then wait out outstanding results and the longest sweep
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic configure(input logic [23:0] glow, input logic [23:0] fade,
                           input logic [7:0] inten, input logic drive);
    reg_write(REG_GLOW, {8'($urandom_range(0, 255)), glow});
    reg_write(REG_FADE, {8'hff, fade});
    reg_write(REG_INTENSITY, {24'hffffff, inten});
    reg_write(REG_MUX_DRIVE, {31'h7fffffff, drive});
  endtask

  task automatic random_items(input int count);
    int sel;
    logic [15:0] cyc;
    logic [7:0] idx;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: cyc = 16'hffff;
        1: cyc = $urandom;
        2: cyc = 16'd0;
        default: cyc = $urandom_range(0, 3000);
      endcase
      idx = ($urandom_range(0, 9) < 7) ? {cur_col, 4'($urandom)} : 8'($urandom);
      if (sel < 25)
        send_item(FUNC_COL, $urandom, $urandom, $urandom, $urandom);
      else if (sel < 55)
        send_item(FUNC_TICK, $urandom, cyc, $urandom, $urandom);
      else if (sel < 67)
        send_item(FUNC_MUX, $urandom, $urandom, ($urandom_range(0, 2) == 0) ?
                  4'($urandom) : 4'($urandom_range(0, 2)), $urandom);
      else
        send_item(FUNC_QUERY, $urandom, $urandom, $urandom, idx);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset-state queries, extremes, mux change seen at a tick
    send_item(FUNC_QUERY, 16'h0, 16'h0, 4'd0, 8'd0);
    send_item(FUNC_QUERY, 16'h0, 16'h0, 4'd0, 8'd255);
    send_item(FUNC_COL, 16'hffff, 16'h0, 4'd0, 8'd0);
    send_item(FUNC_TICK, 16'h0, 16'hffff, 4'd0, 8'd0);
    send_item(FUNC_COL, 16'h0000, 16'h0, 4'd0, 8'd0);
    send_item(FUNC_QUERY, 16'h0, 16'h0, 4'd0, 8'd15);
    drain();
    configure(24'd4651, 24'd534883, 8'd255, 1'b1);
    send_item(FUNC_TICK, 16'h0, 16'd0, 4'd0, 8'd0);
    send_item(FUNC_MUX, 16'h0, 16'h0, 4'd15, 8'd0);
    send_item(FUNC_COL, 16'ha5a5, 16'h0, 4'd0, 8'd0);
    send_item(FUNC_COL, 16'h5a5a, 16'h0, 4'd0, 8'd0);
    send_item(FUNC_TICK, 16'h0, 16'd40000, 4'd0, 8'd0);
    send_item(FUNC_MUX, 16'h0, 16'h0, 4'd0, 8'd0);
    send_item(FUNC_TICK, 16'h0, 16'd500, 4'd0, 8'd0);
    send_item(FUNC_QUERY, 16'h0, 16'h0, 4'd0, 8'd240);
    send_item(FUNC_QUERY, 16'h0, 16'h0, 4'd0, 8'd241);
    send_item(FUNC_QUERY, 16'h0, 16'h0, 4'd0, 8'd0);
    send_item(FUNC_QUERY, 16'h0, 16'h0, 4'd0, 8'd255);
    drain();

    // random phases over register settings, extremes included
    random_items(175);
    drain();
    configure(24'd0, 24'd0, 8'd0, 1'b0);
    random_items(175);
    drain();
    configure(24'hffffff, 24'hffffff, 8'd128, 1'b1);
    random_items(175);
    drain();
    configure(24'($urandom_range(0, 20000)), 24'($urandom_range(0, 200000)),
              8'($urandom), 1'b1);
    random_items(175);
    drain();

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
